// ===== sv/dqe_pkg.sv =====
// ----------------------------------------------------------------------------
// dqe_pkg: shared types and constants for the double-ended queue engine
// Operation and status codes, cell control word, default sizes.
// ----------------------------------------------------------------------------
package dqe_pkg;

  localparam int unsigned DefDepth     = 256;
  localparam int unsigned DefDataWidth = 32;

  typedef enum logic [2:0] {
    OP_PUT_BACK   = 3'd0,
    OP_PUT_FRONT  = 3'd1,
    OP_TAKE_BACK  = 3'd2,
    OP_TAKE_FRONT = 3'd3,
    OP_READ_AT    = 3'd4,
    OP_WRITE_AT   = 3'd5,
    OP_INSERT_AT  = 3'd6,
    OP_ERASE_AT   = 3'd7
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // what every cell does with its word
  typedef enum logic [1:0] {
    CM_HOLD      = 2'd0,
    CM_WRITE     = 2'd1,
    CM_SHIFT_UP  = 2'd2,
    CM_SHIFT_DN  = 2'd3
  } cell_mode_e;

  typedef struct packed {
    cell_mode_e mode;
    logic       snap;
    logic       seek;
  } dqe_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SEEK = 2'b10
  } state_e;

endpackage

// ===== sv/dqe_cell.sv =====
// ----------------------------------------------------------------------------
// dqe_cell: one slot of the queue chain
// Holds one word, takes it from either neighbor on a shift, and carries a
// readout word toward the front of the chain.
// ----------------------------------------------------------------------------
module dqe_cell
  import dqe_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DefDataWidth
) (
  input  logic                  clk_i,
  input  dqe_ctl_t              ctl_i,
  input  logic                  hit_i,
  input  logic                  above_i,
  input  logic [DATA_WIDTH-1:0] left_i,
  input  logic [DATA_WIDTH-1:0] right_i,
  input  logic [DATA_WIDTH-1:0] data_in_i,
  input  logic [DATA_WIDTH-1:0] rd_right_i,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic [DATA_WIDTH-1:0] data_d_o,
  output logic [DATA_WIDTH-1:0] rd_o
);

  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic [DATA_WIDTH-1:0] rd_q, rd_d;

  always_comb begin
    data_d = data_q;
    unique case (ctl_i.mode)
      CM_HOLD: begin
        data_d = data_q;
      end
      CM_WRITE: begin
        if (hit_i) data_d = data_in_i;
      end
      CM_SHIFT_UP: begin
        if (hit_i) begin
          data_d = data_in_i;
        end else if (above_i) begin
          data_d = left_i;
        end
      end
      CM_SHIFT_DN: begin
        if (hit_i || above_i) data_d = right_i;
      end
      default: begin
        data_d = data_q;
      end
    endcase
  end

  // readout word: snapshot of the new contents, then walks one cell per cycle
  always_comb begin
    rd_d = rd_q;
    if (ctl_i.snap) begin
      rd_d = data_d;
    end else if (ctl_i.seek) begin
      rd_d = rd_right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    rd_q   <= rd_d;
  end

  assign data_o   = data_q;
  assign data_d_o = data_d;
  assign rd_o     = rd_q;

endmodule

// ===== sv/double_ended_queue_engine.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_engine: fixed-capacity deque held in a chain of cells
// Push, pop, indexed read/write and indexed insert/erase on DEPTH words.
// ----------------------------------------------------------------------------
// Usage:
//   A command word (func_i, position_i, data_in_i) is taken at a rising edge
//   with start high and busy low. Exactly one result word follows per
//   command, shown for one cycle with result_valid_o: read value, front and
//   back values, occupancy and status. The receiver cannot hold it off.
//   Cell k holds logical element k. Push, pop, write, insert and erase move
//   the whole chain together, so these give their result the cycle after
//   the command and busy stays low: one command per cycle.
//   read_at, and a pop at the back or erase of the last element that leaves
//   the queue non-empty, must fetch a word from the chain: a readout copy of
//   the chain walks toward cell 0 one cell per cycle, and the result follows
//   once index t has reached cell 0, t being the index fetched (position for
//   read_at, new occupancy minus one otherwise); busy is high meanwhile.
//   Reset empties the queue (occupancy zero, no result pending); slot
//   contents are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
module double_ended_queue_engine
  import dqe_pkg::*;
#(
  parameter int unsigned DEPTH      = DefDepth,
  parameter int unsigned DATA_WIDTH = DefDataWidth,
  localparam int unsigned IdxW      = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CntW      = $clog2(DEPTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            func_i,
  input  logic [CntW-1:0]       position_i,
  input  logic [DATA_WIDTH-1:0] data_in_i,
  output logic                  result_valid_o,
  output logic [DATA_WIDTH-1:0] read_value_o,
  output logic [DATA_WIDTH-1:0] front_value_o,
  output logic [DATA_WIDTH-1:0] back_value_o,
  output logic [CntW-1:0]       occupancy_o,
  output logic [1:0]            status_o
);

  state_e                state_q, state_d;
  logic [CntW-1:0]       count_q, count_d;
  logic [DATA_WIDTH-1:0] back_q, back_d;
  logic [IdxW-1:0]       seek_cnt_q, tgt;
  logic                  fetch_rd_q;
  logic                  valid_q;

  logic                  accept, fetch, fetch_rd, emit_now, emit_seek;
  logic                  full, empty;
  cell_mode_e            mode;
  logic [IdxW-1:0]       idx;
  status_e               st;
  dqe_ctl_t              ctl;

  logic [DATA_WIDTH-1:0] cell_q [DEPTH];
  logic [DATA_WIDTH-1:0] cell_d [DEPTH];
  logic [DATA_WIDTH-1:0] rd_w   [DEPTH];

  logic [DATA_WIDTH-1:0] read_value_q, front_value_q, back_value_q;
  logic [CntW-1:0]       occupancy_q;
  status_e               status_q;

  assign accept = start && (state_q == S_IDLE);
  assign full   = (count_q == CntW'(DEPTH));
  assign empty  = (count_q == '0);

  // command decode
  always_comb begin
    mode     = CM_HOLD;
    idx      = '0;
    count_d  = count_q;
    back_d   = back_q;
    st       = ST_OK;
    fetch    = 1'b0;
    fetch_rd = 1'b0;
    tgt      = '0;
    if (accept) begin
      unique case (func_e'(func_i))
        OP_PUT_BACK: begin
          if (full) begin
            st = ST_FULL;
          end else begin
            mode    = CM_WRITE;
            idx     = count_q[IdxW-1:0];
            count_d = count_q + CntW'(1);
            back_d  = data_in_i;
          end
        end
        OP_PUT_FRONT: begin
          if (full) begin
            st = ST_FULL;
          end else begin
            mode    = CM_SHIFT_UP;
            count_d = count_q + CntW'(1);
            if (empty) back_d = data_in_i;
          end
        end
        OP_TAKE_BACK: begin
          if (empty) begin
            st = ST_EMPTY;
          end else begin
            count_d = count_q - CntW'(1);
            if (count_q >= CntW'(2)) begin
              fetch = 1'b1;
              tgt   = IdxW'(count_q - CntW'(2));
            end
          end
        end
        OP_TAKE_FRONT: begin
          if (empty) begin
            st = ST_EMPTY;
          end else begin
            mode    = CM_SHIFT_DN;
            count_d = count_q - CntW'(1);
          end
        end
        OP_READ_AT: begin
          if (position_i >= count_q) begin
            st = ST_RANGE;
          end else begin
            fetch    = 1'b1;
            fetch_rd = 1'b1;
            tgt      = position_i[IdxW-1:0];
          end
        end
        OP_WRITE_AT: begin
          if (position_i >= count_q) begin
            st = ST_RANGE;
          end else begin
            mode = CM_WRITE;
            idx  = position_i[IdxW-1:0];
            if (position_i == count_q - CntW'(1)) back_d = data_in_i;
          end
        end
        OP_INSERT_AT: begin
          if (full) begin
            st = ST_FULL;
          end else if (position_i > count_q) begin
            st = ST_RANGE;
          end else begin
            mode    = CM_SHIFT_UP;
            idx     = position_i[IdxW-1:0];
            count_d = count_q + CntW'(1);
            if (position_i == count_q) back_d = data_in_i;
          end
        end
        OP_ERASE_AT: begin
          if (empty) begin
            st = ST_EMPTY;
          end else if (position_i >= count_q) begin
            st = ST_RANGE;
          end else begin
            mode    = CM_SHIFT_DN;
            idx     = position_i[IdxW-1:0];
            count_d = count_q - CntW'(1);
            // erasing the last element exposes a new back word
            if ((position_i == count_q - CntW'(1)) && (count_q >= CntW'(2))) begin
              fetch = 1'b1;
              tgt   = IdxW'(count_q - CntW'(2));
            end
          end
        end
        default: begin
          st = ST_OK;
        end
      endcase
    end
  end

  assign emit_now  = accept && !fetch;
  assign emit_seek = (state_q == S_SEEK) && (seek_cnt_q == '0);

  assign ctl.mode = mode;
  assign ctl.snap = accept && fetch;
  assign ctl.seek = (state_q == S_SEEK) && (seek_cnt_q != '0);

  // chain of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w, right_w, rd_right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w    = '0;
      assign rd_right_w = '0;
    end else begin : g_mid_r
      assign right_w    = cell_q[i+1];
      assign rd_right_w = rd_w[i+1];
    end

    dqe_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk_i     (clk_i),
      .ctl_i     (ctl),
      .hit_i     (idx == IdxW'(i)),
      .above_i   (IdxW'(i) > idx),
      .left_i    (left_w),
      .right_i   (right_w),
      .data_in_i (data_in_i),
      .rd_right_i(rd_right_w),
      .data_o    (cell_q[i]),
      .data_d_o  (cell_d[i]),
      .rd_o      (rd_w[i])
    );
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && fetch) state_d = S_SEEK;
      end
      S_SEEK: begin
        if (emit_seek) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      valid_q <= emit_now || emit_seek;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      back_q     <= back_d;
      seek_cnt_q <= tgt;
      fetch_rd_q <= fetch_rd;
    end else begin
      if (emit_seek && !fetch_rd_q) back_q <= rd_w[0];
      if (ctl.seek) seek_cnt_q <= seek_cnt_q - IdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_now) begin
      read_value_q  <= '0;
      front_value_q <= (count_d == '0) ? '0 : cell_d[0];
      back_value_q  <= (count_d == '0) ? '0 : back_d;
      occupancy_q   <= count_d;
      status_q      <= st;
    end else if (emit_seek) begin
      read_value_q  <= fetch_rd_q ? rd_w[0] : '0;
      front_value_q <= cell_q[0];
      back_value_q  <= fetch_rd_q ? back_q : rd_w[0];
      occupancy_q   <= count_q;
      status_q      <= ST_OK;
    end
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = valid_q;
  assign read_value_o   = read_value_q;
  assign front_value_o  = front_value_q;
  assign back_value_o   = back_value_q;
  assign occupancy_o    = occupancy_q;
  assign status_o       = status_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("occupancy beyond capacity");

  a_result_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result shown while still busy");

  a_quick_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !fetch) |=> (result_valid_o && !busy))
    else $error("chain operation gave no result next cycle");

  a_seek_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_SEEK) && (seek_cnt_q != '0)) |=>
      ((state_q == S_SEEK) && (seek_cnt_q == $past(seek_cnt_q) - IdxW'(1))))
    else $error("readout walk lost a step");

endmodule

// ===== tb/sv/tb_double_ended_queue_engine.sv =====
// ----------------------------------------------------------------------------
// tb_double_ended_queue_engine: self-checking bench for the deque engine
// A short directed table covers the empty and range corners, every operation
// and the field extremes. It is followed by a random walk of commands that
// drives the occupancy between empty and full under three sender idle
// profiles. Every result word is checked against a behavioral deque kept in
// the bench, or against the answer pinned to its table row.
// ----------------------------------------------------------------------------
module tb_double_ended_queue_engine
  import dqe_pkg::*;
();

  localparam int unsigned Depth = DefDepth;
  localparam int unsigned Dw    = DefDataWidth;
  localparam int unsigned IdxW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int          RandomPerPhase = 284;
  localparam int          RingDepth = 64;

  typedef struct packed {
    logic [Dw-1:0]   read_value;
    logic [Dw-1:0]   front_value;
    logic [Dw-1:0]   back_value;
    logic [CntW-1:0] occupancy;
    status_e         status;
  } outcome_t;

  typedef struct packed {
    func_e           op;
    logic [CntW-1:0] pos;
    logic [Dw-1:0]   data;
    logic            pinned;
    outcome_t        want;
  } step_row_t;

  // pinned rows carry their own answer, the rest go through the deque mirror
  localparam int NumRows = 26;
  localparam step_row_t DirectedRows [NumRows] = '{
    '{OP_TAKE_BACK,  9'h000, 32'h0000_0000, 1'b1, '{32'h0, 32'h0, 32'h0, 9'd0, ST_EMPTY}},
    '{OP_TAKE_FRONT, 9'h1FF, 32'hFFFF_FFFF, 1'b1, '{32'h0, 32'h0, 32'h0, 9'd0, ST_EMPTY}},
    '{OP_ERASE_AT,   9'h1FF, 32'h0000_0000, 1'b1, '{32'h0, 32'h0, 32'h0, 9'd0, ST_EMPTY}},
    '{OP_READ_AT,    9'h000, 32'h0000_0000, 1'b1, '{32'h0, 32'h0, 32'h0, 9'd0, ST_RANGE}},
    '{OP_WRITE_AT,   9'h100, 32'hFFFF_FFFF, 1'b1, '{32'h0, 32'h0, 32'h0, 9'd0, ST_RANGE}},
    '{OP_INSERT_AT,  9'h001, 32'h0000_0000, 1'b1, '{32'h0, 32'h0, 32'h0, 9'd0, ST_RANGE}},
    '{OP_INSERT_AT,  9'h000, 32'hFFFF_FFFF, 1'b1,
      '{32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 9'd1, ST_OK}},
    '{OP_PUT_BACK,   9'h1FF, 32'h0000_0000, 1'b1,
      '{32'h0, 32'hFFFF_FFFF, 32'h0, 9'd2, ST_OK}},
    '{OP_PUT_FRONT,  9'h000, 32'h8000_0001, 1'b1,
      '{32'h0, 32'h8000_0001, 32'h0, 9'd3, ST_OK}},
    '{OP_READ_AT,    9'h001, 32'h0000_0000, 1'b1,
      '{32'hFFFF_FFFF, 32'h8000_0001, 32'h0, 9'd3, ST_OK}},
    '{OP_READ_AT,    9'h003, 32'h0000_0000, 1'b1,
      '{32'h0, 32'h8000_0001, 32'h0, 9'd3, ST_RANGE}},
    '{OP_READ_AT,    9'h1FF, 32'h0000_0000, 1'b1,
      '{32'h0, 32'h8000_0001, 32'h0, 9'd3, ST_RANGE}},
    '{OP_WRITE_AT,   9'h002, 32'h5A5A_A5A5, 1'b1,
      '{32'h0, 32'h8000_0001, 32'h5A5A_A5A5, 9'd3, ST_OK}},
    // insert at the occupancy appends at the back
    '{OP_INSERT_AT,  9'h003, 32'h1234_5678, 1'b1,
      '{32'h0, 32'h8000_0001, 32'h1234_5678, 9'd4, ST_OK}},
    '{OP_INSERT_AT,  9'h001, 32'h0F0F_F0F0, 1'b0, '0},
    '{OP_INSERT_AT,  9'h000, 32'hC3C3_C3C3, 1'b0, '0},
    '{OP_READ_AT,    9'h002, 32'h0000_0000, 1'b0, '0},
    '{OP_ERASE_AT,   9'h005, 32'h0000_0000, 1'b0, '0},
    '{OP_ERASE_AT,   9'h000, 32'h0000_0000, 1'b0, '0},
    '{OP_ERASE_AT,   9'h001, 32'h0000_0000, 1'b0, '0},
    '{OP_ERASE_AT,   9'h003, 32'h0000_0000, 1'b0, '0},
    '{OP_TAKE_BACK,  9'h000, 32'h0000_0000, 1'b0, '0},
    '{OP_WRITE_AT,   9'h000, 32'hDEAD_BEEF, 1'b0, '0},
    '{OP_TAKE_FRONT, 9'h000, 32'h0000_0000, 1'b1,
      '{32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 9'd1, ST_OK}},
    '{OP_PUT_BACK,   9'h0AA, 32'hAAAA_AAAA, 1'b0, '0},
    '{OP_PUT_FRONT,  9'h155, 32'h5555_5555, 1'b0, '0}
  };

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            start = 1'b0;
  logic            busy;
  logic [2:0]      func_i = OP_PUT_BACK;
  logic [CntW-1:0] position_i = '0;
  logic [Dw-1:0]   data_in_i = '0;
  logic            result_valid_o;
  logic [Dw-1:0]   read_value_o;
  logic [Dw-1:0]   front_value_o;
  logic [Dw-1:0]   back_value_o;
  logic [CntW-1:0] occupancy_o;
  logic [1:0]      status_o;

  // answer that travels with a pinned table row
  logic            pin_on = 1'b0;
  outcome_t        pin_want = '0;

  // behavioral copy of the deque
  logic [Dw-1:0]   mirror_slots [Depth];
  logic [IdxW-1:0] mirror_head = '0;
  logic [CntW-1:0] mirror_count = '0;

  // expected result words in order, as a ring with free-running counters
  outcome_t outstanding [RingDepth];
  int       out_wr = 0;
  int       out_rd = 0;
  int       mismatches = 0;
  int       commands_taken = 0;
  int       results_checked = 0;
  int       status_tally [4] = '{0, 0, 0, 0};
  int       peak_fill = 0;

  double_ended_queue_engine dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .position_i     (position_i),
    .data_in_i      (data_in_i),
    .result_valid_o (result_valid_o),
    .read_value_o   (read_value_o),
    .front_value_o  (front_value_o),
    .back_value_o   (back_value_o),
    .occupancy_o    (occupancy_o),
    .status_o       (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #60_000_000;
    $display("tb_double_ended_queue_engine NOT OK");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [Dw-1:0] got,
                             input logic [Dw-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("word %0d %s: got %h, expected %h",
                                results_checked, name, got, want));
  endtask

  function automatic logic [IdxW-1:0] slot_of(input int lidx);
    return IdxW'((int'(mirror_head) + lidx) % Depth);
  endfunction

  task automatic deque_predict(input func_e op, input logic [CntW-1:0] pos,
                               input logic [Dw-1:0] word, output outcome_t res);
    int i;
    res = '0;
    case (op)
      OP_PUT_BACK: begin
        if (mirror_count == Depth) begin
          res.status = ST_FULL;
        end else begin
          mirror_slots[slot_of(int'(mirror_count))] = word;
          mirror_count++;
        end
      end
      OP_PUT_FRONT: begin
        if (mirror_count == Depth) begin
          res.status = ST_FULL;
        end else begin
          mirror_head = IdxW'((int'(mirror_head) + Depth - 1) % Depth);
          mirror_slots[mirror_head] = word;
          mirror_count++;
        end
      end
      OP_TAKE_BACK: begin
        if (mirror_count == 0) res.status = ST_EMPTY;
        else mirror_count--;
      end
      OP_TAKE_FRONT: begin
        if (mirror_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          mirror_head = IdxW'((int'(mirror_head) + 1) % Depth);
          mirror_count--;
        end
      end
      OP_READ_AT: begin
        if (pos >= mirror_count) res.status = ST_RANGE;
        else res.read_value = mirror_slots[slot_of(int'(pos))];
      end
      OP_WRITE_AT: begin
        if (pos >= mirror_count) res.status = ST_RANGE;
        else mirror_slots[slot_of(int'(pos))] = word;
      end
      OP_INSERT_AT: begin
        // full is checked before the index
        if (mirror_count == Depth) begin
          res.status = ST_FULL;
        end else if (pos > mirror_count) begin
          res.status = ST_RANGE;
        end else begin
          for (i = int'(mirror_count); i > int'(pos); i--)
            mirror_slots[slot_of(i)] = mirror_slots[slot_of(i - 1)];
          mirror_slots[slot_of(int'(pos))] = word;
          mirror_count++;
        end
      end
      default: begin
        // erase: empty is checked before the index
        if (mirror_count == 0) begin
          res.status = ST_EMPTY;
        end else if (pos >= mirror_count) begin
          res.status = ST_RANGE;
        end else begin
          for (i = int'(pos); i + 1 < int'(mirror_count); i++)
            mirror_slots[slot_of(i)] = mirror_slots[slot_of(i + 1)];
          mirror_count--;
        end
      end
    endcase
    if (mirror_count != 0) begin
      res.front_value = mirror_slots[slot_of(0)];
      res.back_value  = mirror_slots[slot_of(int'(mirror_count) - 1)];
    end
    res.occupancy = mirror_count;
  endtask

  always @(posedge clk_i) begin : monitor
    outcome_t want;
    if (rst_ni) begin
      if (result_valid_o) begin
        status_tally[status_o]++;
        if (int'(occupancy_o) > peak_fill) peak_fill = int'(occupancy_o);
        if (out_wr == out_rd) begin
          report_mismatch($sformatf("result word with nothing outstanding (occ %0d)",
                                    occupancy_o));
        end else begin
          want = outstanding[out_rd % RingDepth];
          out_rd++;
          check_field("read_value", read_value_o, want.read_value);
          check_field("front_value", front_value_o, want.front_value);
          check_field("back_value", back_value_o, want.back_value);
          check_field("occupancy", Dw'(occupancy_o), Dw'(want.occupancy));
          check_field("status", Dw'(status_o), Dw'(want.status));
          results_checked++;
        end
      end
      if (start && !busy) begin
        deque_predict(func_e'(func_i), position_i, data_in_i, want);
        if (pin_on) want = pin_want;
        outstanding[out_wr % RingDepth] = want;
        out_wr++;
        commands_taken++;
      end
    end
  end

  // occupancy after a command, so the stimulus can steer without the mirror
  function automatic int next_fill(input func_e op, input int pos, input int fill);
    case (op)
      OP_PUT_BACK, OP_PUT_FRONT: return (fill < int'(Depth)) ? fill + 1 : fill;
      OP_INSERT_AT: return (fill < int'(Depth) && pos <= fill) ? fill + 1 : fill;
      OP_TAKE_BACK, OP_TAKE_FRONT: return (fill > 0) ? fill - 1 : fill;
      OP_ERASE_AT: return (pos < fill) ? fill - 1 : fill;
      default: return fill;
    endcase
  endfunction

  task automatic send_word(input func_e op, input logic [CntW-1:0] pos,
                           input logic [Dw-1:0] word, input logic pinned,
                           input outcome_t want);
    start      <= 1'b1;
    func_i     <= op;
    position_i <= pos;
    data_in_i  <= word;
    pin_on     <= pinned;
    pin_want   <= want;
    do @(posedge clk_i); while (busy);
  endtask

  // idle cycles carry junk on the func_i command field
  task automatic sender_gap(input int pct);
    while ($urandom_range(99) < pct) begin
      start  <= 1'b0;
      func_i <= 3'($urandom());
      @(posedge clk_i);
    end
  endtask

  // step past the current edge first so the word taken there is counted
  task automatic drain_outstanding();
    start <= 1'b0;
    @(posedge clk_i);
    while (out_wr != out_rd) @(posedge clk_i);
  endtask

  task automatic pick_command(inout int fill, inout int goal, output func_e op,
                              output logic [CntW-1:0] pos, output logic [Dw-1:0] word);
    int roll;
    int pick;
    if (fill == goal) begin
      pick = $urandom_range(99);
      goal = (pick < 40) ? 0 : (pick < 80) ? int'(Depth) : $urandom_range(1, Depth - 1);
    end
    roll = $urandom_range(99);
    pick = $urandom_range(2);
    if (roll < 15) begin
      op = pick[0] ? OP_READ_AT : OP_WRITE_AT;
    end else if ((roll < 85) == (goal > fill)) begin
      op = (pick == 0) ? OP_PUT_BACK : (pick == 1) ? OP_PUT_FRONT : OP_INSERT_AT;
    end else begin
      op = (pick == 0) ? OP_TAKE_BACK : (pick == 1) ? OP_TAKE_FRONT : OP_ERASE_AT;
    end
    if ($urandom_range(99) < 8) begin
      pos = CntW'($urandom_range(0, 2 ** CntW - 1));
    end else begin
      case (op)
        OP_INSERT_AT: pos = CntW'($urandom_range(0, fill));
        OP_READ_AT, OP_WRITE_AT, OP_ERASE_AT:
          pos = CntW'((fill > 0) ? $urandom_range(0, fill - 1) : 0);
        default: pos = CntW'($urandom_range(0, 2 ** CntW - 1));
      endcase
    end
    roll = $urandom_range(9);
    word = (roll == 0) ? '0 : (roll == 1) ? '1 : Dw'($urandom());
    fill = next_fill(op, int'(pos), fill);
  endtask

  initial begin : stimulus
    int              fill;
    int              goal;
    int              phase;
    int              n;
    int              idle_pct [3];
    func_e           op;
    logic [CntW-1:0] pos;
    logic [Dw-1:0]   word;

    idle_pct = '{7, 70, 0};
    fill = 0;
    goal = Depth;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (n = 0; n < NumRows; n++) begin
      send_word(DirectedRows[n].op, DirectedRows[n].pos, DirectedRows[n].data,
                DirectedRows[n].pinned, DirectedRows[n].want);
      fill = next_fill(DirectedRows[n].op, int'(DirectedRows[n].pos), fill);
    end
    drain_outstanding();

    for (phase = 0; phase < 3; phase++) begin
      for (n = 0; n < RandomPerPhase; n++) begin
        sender_gap(idle_pct[phase]);
        pick_command(fill, goal, op, pos, word);
        send_word(op, pos, word, 1'b0, '0);
      end
      // hold off until the engine has answered everything
      drain_outstanding();
    end

    repeat (Depth + 4) @(posedge clk_i);
    if (out_wr != out_rd)
      report_mismatch($sformatf("%0d result words never arrived", out_wr - out_rd));

    $display("run: %0d commands, %0d result words checked, peak occupancy %0d",
             commands_taken, results_checked, peak_fill);
    $display("status seen: ok %0d, full %0d, empty %0d, range %0d",
             status_tally[ST_OK], status_tally[ST_FULL], status_tally[ST_EMPTY],
             status_tally[ST_RANGE]);
    if (mismatches == 0) begin
      $display("tb_double_ended_queue_engine OK");
    end else begin
      $display("tb_double_ended_queue_engine NOT OK");
    end
    $finish;
  end

endmodule
